FILE: src/tssce_pkg.sv
`timescale 1ns / 1ps

package tssce_pkg;

    // fixed-point formats
    localparam int FRAC_BITS  = 24;
    localparam int ARG_W      = 32;
    localparam int OUT_W      = 40;

    // configuration port
    localparam int MODE_W     = 2;
    localparam int TERMS_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT    = 2'd1;

    localparam logic [MODE_W-1:0] MODE_SIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXP = 2'd2;

    localparam logic [TERMS_W-1:0] TERM_COUNT_RST = 6'd8;

    // shared multiplier: four half-width partial products
    localparam int HALF_W    = OUT_W / 2;
    localparam int PROD_W    = 2 * OUT_W;
    localparam int RND_W     = PROD_W + 1;
    localparam int P_W       = RND_W - FRAC_BITS;
    localparam int MUL_STEPS = 4;

    // divider: DIV_BITS quotient bits per cycle
    localparam int DIVN_W    = P_W + 1;
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = OUT_W / DIV_BITS;
    localparam int STEP_W    = 3;

    localparam logic [OUT_W-1:0] POS_LIM  = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_LIM  = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] FIX_ONE  = OUT_W'(1) << FRAC_BITS;
    localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (FRAC_BITS - 1);

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       sq_sel;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       sq_fin;
        logic       ld_div;
        logic       rnd;
        logic       div_en;
        logic       acc;
        logic       ld_out;
    } t_dp_cmd;

endpackage

FILE: src/tssce_dp.sv
`timescale 1ns / 1ps

module tssce_dp #(
    parameter int  MAX_TERMS = 32,
    localparam int CNT_W     = $clog2(MAX_TERMS + 1)
) (
    input  logic                                 i_clk,
    input  tssce_pkg::t_dp_cmd                   i_cmd,
    input  logic [CNT_W-1:0]                     i_term_idx,
    input  logic [tssce_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [tssce_pkg::ARG_W-1:0]   i_argument,
    output logic signed [tssce_pkg::OUT_W-1:0]   o_approximation,
    output logic                                 o_overflow
);
    import tssce_pkg::*;

    localparam int D_W  = $clog2(4 * MAX_TERMS * MAX_TERMS + 1);
    localparam int DC_W = 2 * CNT_W + 3;
    localparam int HI_W = DIVN_W - OUT_W;

    logic [OUT_W-1:0]  r_m;
    logic              r_mneg;
    logic [OUT_W-1:0]  r_tmag;
    logic              r_tneg;
    logic [OUT_W-1:0]  r_sum;
    logic              r_ovf;
    logic [PROD_W-1:0] r_acc;
    logic [D_W-1:0]    r_div;
    logic [D_W-1:0]    r_rem;
    logic [OUT_W-1:0]  r_quo;
    logic              r_sat;
    logic [OUT_W-1:0]  r_approx;
    logic              r_ovf_out;

    logic              is_exp;
    logic              is_sin;
    logic [ARG_W-1:0]  arg_u;
    logic              arg_neg;
    logic [ARG_W-1:0]  n_xm;
    logic [OUT_W-1:0]  arg_ext;

    logic [OUT_W-1:0]  a_op;
    logic [HALF_W-1:0] a_part;
    logic [HALF_W-1:0] b_part;
    logic [OUT_W-1:0]  pp;
    logic [PROD_W-1:0] pp_ext;
    logic [PROD_W-1:0] pp_sh;
    logic [1:0]        sh;
    logic [PROD_W-1:0] n_acc;

    logic [RND_W-1:0]  rnd;
    logic              big;
    logic [P_W-1:0]    p;
    logic [DIVN_W-1:0] divn;
    logic [HI_W-1:0]   div_hi;
    logic              div_ovf;

    logic [DC_W-1:0]   idx_ext;
    logic [DC_W-1:0]   d_sq;
    logic [DC_W-1:0]   n_dcalc;

    logic [D_W-1:0]    n_rem;
    logic [OUT_W-1:0]  n_quo;

    logic              neg;
    logic [OUT_W-1:0]  lim;
    logic              tsat;
    logic [OUT_W-1:0]  mag;
    logic [OUT_W:0]    tval;
    logic [OUT_W:0]    sum_w;
    logic              ssat;
    logic [OUT_W-1:0]  n_sum;

    // decode mode and argument magnitude
    assign is_exp  = i_mode[1];
    assign is_sin  = (i_mode == MODE_SIN);
    assign arg_u   = i_argument;
    assign arg_neg = arg_u[ARG_W-1];
    assign n_xm    = arg_neg ? (ARG_W'(0) - arg_u) : arg_u;
    assign arg_ext = {{(OUT_W-ARG_W){arg_u[ARG_W-1]}}, arg_u};

    // one half-width partial product per cycle, accumulated
    always_comb begin
        a_op   = i_cmd.sq_sel ? r_m : r_tmag;
        a_part = i_cmd.mul_step[0] ? a_op[OUT_W-1:HALF_W] : a_op[HALF_W-1:0];
        b_part = i_cmd.mul_step[1] ? r_m[OUT_W-1:HALF_W] : r_m[HALF_W-1:0];
        pp     = OUT_W'(a_part * b_part);
        pp_ext = PROD_W'(pp);
        sh     = {1'b0, i_cmd.mul_step[0]} + {1'b0, i_cmd.mul_step[1]};
        case (sh)
            2'd0:    pp_sh = pp_ext;
            2'd1:    pp_sh = pp_ext << HALF_W;
            default: pp_sh = pp_ext << (2 * HALF_W);
        endcase
        n_acc = (i_cmd.mul_step == 2'd0) ? pp_sh : (r_acc + pp_sh);
    end

    // round the product, add half the divisor, split off the high part
    always_comb begin
        rnd     = {1'b0, r_acc} + RND_HALF;
        big     = (rnd >> (FRAC_BITS + 63)) != '0;
        p       = rnd[RND_W-1:FRAC_BITS];
        divn    = {1'b0, p} + DIVN_W'(r_div >> 1);
        div_hi  = divn[DIVN_W-1:OUT_W];
        div_ovf = div_hi >= HI_W'(r_div);
    end

    // divisor for term i
    always_comb begin
        idx_ext = DC_W'(i_term_idx);
        d_sq    = DC_W'(idx_ext * idx_ext) << 2;
        if (is_exp) begin
            n_dcalc = idx_ext;
        end else if (is_sin) begin
            n_dcalc = d_sq + (idx_ext << 1);
        end else begin
            n_dcalc = d_sq - (idx_ext << 1);
        end
    end

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        logic [D_W:0] trial;
        logic         qbit;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {n_rem, n_quo[OUT_W-1]};
            qbit  = trial >= {1'b0, r_div};
            if (qbit) begin
                trial = trial - {1'b0, r_div};
            end
            n_rem = trial[D_W-1:0];
            n_quo = {n_quo[OUT_W-2:0], qbit};
        end
    end

    // saturate the term and add it to the sum
    always_comb begin
        neg   = r_tneg ^ r_mneg;
        lim   = neg ? NEG_LIM : POS_LIM;
        tsat  = r_sat || (r_quo > lim);
        mag   = tsat ? lim : r_quo;
        tval  = neg ? ((OUT_W+1)'(0) - {1'b0, mag}) : {1'b0, mag};
        sum_w = {r_sum[OUT_W-1], r_sum} + tval;
        ssat  = sum_w[OUT_W] != sum_w[OUT_W-1];
        if (ssat) begin
            n_sum = sum_w[OUT_W] ? NEG_LIM : POS_LIM;
        end else begin
            n_sum = sum_w[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        // load the first term
        if (i_cmd.load) begin
            r_m    <= OUT_W'(n_xm);
            r_mneg <= is_exp ? arg_neg : 1'b1;
            r_ovf  <= 1'b0;
            if (is_sin) begin
                r_tmag <= OUT_W'(n_xm);
                r_tneg <= arg_neg;
                r_sum  <= arg_ext;
            end else begin
                r_tmag <= FIX_ONE;
                r_tneg <= 1'b0;
                r_sum  <= FIX_ONE;
            end
        end
        if (i_cmd.mul_en) begin
            r_acc <= n_acc;
        end
        // x*x rounded becomes the multiplier
        if (i_cmd.sq_fin) begin
            r_m <= rnd[FRAC_BITS+OUT_W-1:FRAC_BITS];
        end
        if (i_cmd.ld_div) begin
            r_div <= n_dcalc[D_W-1:0];
        end
        if (i_cmd.rnd) begin
            r_quo <= divn[OUT_W-1:0];
            r_rem <= div_hi[D_W-1:0];
            r_sat <= big | div_ovf;
        end
        if (i_cmd.div_en) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (i_cmd.acc) begin
            r_tmag <= mag;
            r_tneg <= neg & (mag != '0);
            r_sum  <= n_sum;
            r_ovf  <= r_ovf | tsat | ssat;
        end
        // hold the result for the output channel
        if (i_cmd.ld_out) begin
            r_approx  <= r_sum;
            r_ovf_out <= r_ovf;
        end
    end

    assign o_approximation = r_approx;
    assign o_overflow      = r_ovf_out;

endmodule

FILE: src/tssce_ctrl.sv
`timescale 1ns / 1ps

module tssce_ctrl #(
    parameter int  MAX_TERMS = 32,
    localparam int CNT_W     = $clog2(MAX_TERMS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tssce_pkg::MODE_W-1:0]  i_mode,
    input  logic [tssce_pkg::TERMS_W-1:0] i_term_count,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tssce_pkg::t_dp_cmd            o_cmd,
    output logic [CNT_W-1:0]              o_term_idx
);
    import tssce_pkg::*;

    localparam int N_W = (CNT_W > TERMS_W) ? CNT_W : TERMS_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_SQFIN = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_RND   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [N_W-1:0]    n_terms;
    t_dp_cmd           cmd;

    // clamp the term count to 1..MAX_TERMS
    always_comb begin
        if (i_term_count == '0) begin
            n_terms = N_W'(1);
        end else if (N_W'(i_term_count) > N_W'(MAX_TERMS)) begin
            n_terms = N_W'(MAX_TERMS);
        end else begin
            n_terms = N_W'(i_term_count);
        end
    end

    // sequence the datapath
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_idx   = r_idx;
        cmd     = '0;
        cmd.mul_step = r_step[1:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_idx    = CNT_W'(1);
                    n_step   = '0;
                    n_state  = i_mode[1] ? S_CHK : S_SQ;
                end
            end
            S_SQ: begin
                cmd.mul_en = 1'b1;
                cmd.sq_sel = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_SQFIN;
                end
            end
            S_SQFIN: begin
                cmd.sq_fin = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (N_W'(r_idx) >= n_terms) begin
                    n_state = S_DONE;
                end else begin
                    cmd.ld_div = 1'b1;
                    n_step     = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_RND;
                end
            end
            S_RND: begin
                cmd.rnd = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.div_en = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                n_idx   = r_idx + 1'b1;
                n_state = S_CHK;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.ld_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, drop when the item is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
    assign o_term_idx  = r_idx;

endmodule

FILE: src/truncated_series_sin_cos_exp_top.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_argument (Q8.24)
// output    out        o_out_valid / i_out_stall  o_approximation (Q16.24), o_overflow
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// The input stalls while an item is in work, so items do not overlap.
// Each term takes four passes through one 20x20 multiplier and five passes
// through an 8-bit-per-cycle divider; for sine and cosine, squaring x takes four more passes.
// Reset is synchronous and active low; it restores mode sine and 8 terms.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and the block holds its result only if that register is full and stalled.
`timescale 1ns / 1ps

module truncated_series_sin_cos_exp_top #(
    parameter int MAX_TERMS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [tssce_pkg::ARG_W-1:0]   i_argument,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [tssce_pkg::OUT_W-1:0]   o_approximation,
    output logic                                 o_overflow,
    input  logic                                 i_cfg_we,
    input  logic [tssce_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tssce_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tssce_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    logic [MODE_W-1:0]  r_mode;
    logic [TERMS_W-1:0] r_term_count;
    t_dp_cmd            cmd;
    logic [CNT_W-1:0]   term_idx;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SIN;
            r_term_count <= TERM_COUNT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_FUNCTION_MODE) begin
                r_mode <= i_cfg_data[MODE_W-1:0];
            end else if (i_cfg_index == REG_TERM_COUNT) begin
                r_term_count <= i_cfg_data[TERMS_W-1:0];
            end
        end
    end

    tssce_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_term_count (r_term_count),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cmd        (cmd),
        .o_term_idx   (term_idx)
    );

    tssce_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .i_term_idx      (term_idx),
        .i_mode          (r_mode),
        .i_argument      (i_argument),
        .o_approximation (o_approximation),
        .o_overflow      (o_overflow)
    );

    // an accepted item makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    // a new result only appears at the end of an item's work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

    // leaving the busy phase loads the output register
    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_in_stall) && $past(i_rst_n)) |-> o_out_valid)
        else $error("block went idle without presenting its result");

endmodule
